// ===== src/isar_pkg.sv =====
// shared types and constants for the interval set add/remove block
package isar_pkg;

  localparam int MAX_INTERVALS = 16;
  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] ST_CHANGED   = 2'd0;
  localparam logic [1:0] ST_UNCHANGED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BADRANGE  = 2'd3;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               entry_valid;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_low;
    logic signed [31:0] entry_high;
    logic [4:0]         entry_total;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic stream;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic scan_done;
    logic last_load;
  } sts_t;

endpackage

// ===== src/interval_set_add_remove_top.sv =====
// Sorted interval set with add and remove. Each request takes a rebuild pass over the
// stored table, one step per cycle through the single table read port (an add ends early
// when a stored interval covers it), and then streams one result per stored interval (a
// single empty result when the table is empty) through the output register, one per
// cycle when rsp_ready stays high; a request with low above high skips the pass. The old
// table is kept in a second bank until the rebuild succeeds, so a rejected request leaves
// it untouched.
module interval_set_add_remove_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  isar_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output isar_pkg::rsp_t   rsp
);

  isar_pkg::cmd_t cmd;
  isar_pkg::sts_t sts;

  // control
  isar_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .sts(sts), .cmd(cmd)
  );

  // data
  isar_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req), .sts(sts),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

endmodule

// ===== src/isar_ctrl.sv =====
// controller state machine: accept, rebuild pass, result streaming
module isar_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  isar_pkg::sts_t   sts,
  output isar_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    SCAN   = 3'b010,
    STREAM = 3'b100
  } state_t;

  state_t state, state_next;

  // command decode
  always_comb begin
    req_ready  = (state == IDLE);
    cmd.load   = req_valid && (state == IDLE);
    cmd.scan   = (state == SCAN);
    cmd.stream = (state == STREAM);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (req_valid) state_next = sts.bad ? STREAM : SCAN;
      end
      SCAN: begin
        if (sts.scan_done) state_next = STREAM;
      end
      STREAM: begin
        if (sts.last_load) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else     state <= state_next;
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_done_only_scan: assert property (@(posedge clk) disable iff (rst)
    sts.scan_done |-> state == SCAN) else $error("scan done outside scan");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !req_ready) else $error("request taken while busy");

endmodule

// ===== src/isar_dp.sv =====
// datapath: ping-pong interval table, rebuild step logic and output register
module isar_dp (
  input  logic             clk,
  input  logic             rst,
  input  isar_pkg::cmd_t   cmd,
  input  isar_pkg::req_t   req,
  output isar_pkg::sts_t   sts,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output isar_pkg::rsp_t   rsp
);

  localparam logic [isar_pkg::CNT_W-1:0] MAXC = isar_pkg::CNT_W'(isar_pkg::MAX_INTERVALS);

  logic signed [31:0] tab_low  [2][isar_pkg::MAX_INTERVALS];
  logic signed [31:0] tab_high [2][isar_pkg::MAX_INTERVALS];
  logic               sel;
  logic [isar_pkg::CNT_W-1:0] cnt, i, j;
  logic               op;
  logic signed [31:0] lo, hi, mlo, mhi;
  logic               ins, phase, changed, full;
  logic [1:0]         status;

  logic [isar_pkg::IDX_W-1:0] ridx;
  logic signed [31:0] rlo, rhi, wlo, whi, ilo, ihi;
  logic at_end, wr, adv, done, merge, set_ins, set_chg, ph_next, fin_chg, ld, is_last;

  // table read at the scan / stream pointer
  always_comb begin
    ridx = i[isar_pkg::IDX_W-1:0];
    rlo  = tab_low[sel][ridx];
    rhi  = tab_high[sel][ridx];
    ilo  = (rlo > lo) ? rlo : lo;
    ihi  = (rhi < hi) ? rhi : hi;
    at_end = (i == cnt);
  end

  // one rebuild step per cycle
  always_comb begin
    wr = 1'b0; wlo = rlo; whi = rhi; adv = 1'b0; done = 1'b0;
    merge = 1'b0; set_ins = 1'b0; set_chg = 1'b0; ph_next = phase;
    if (op == isar_pkg::FUNC_ADD) begin
      if (at_end) begin
        if (!ins) begin
          wr = 1'b1; wlo = mlo; whi = mhi; set_ins = 1'b1;
        end else begin
          done = 1'b1; set_chg = 1'b1;
        end
      end else if (rlo <= lo && hi <= rhi) begin
        done = 1'b1;
      end else if (lo <= rhi && rlo <= hi) begin
        merge = 1'b1; adv = 1'b1;
      end else if (!ins && rlo > hi) begin
        wr = 1'b1; wlo = mlo; whi = mhi; set_ins = 1'b1;
      end else begin
        wr = 1'b1; adv = 1'b1;
      end
    end else begin
      if (at_end) begin
        done = 1'b1;
      end else if (ilo < ihi) begin
        set_chg = 1'b1;
        if (!phase) begin
          wr = (rlo < lo); wlo = rlo; whi = lo; ph_next = 1'b1;
        end else begin
          wr = (rhi > hi); wlo = hi; whi = rhi; ph_next = 1'b0; adv = 1'b1;
        end
      end else begin
        wr = 1'b1; adv = 1'b1;
      end
    end
    fin_chg = changed | set_chg;
  end

  // status towards the controller
  always_comb begin
    ld            = cmd.stream && (!rsp_valid || rsp_ready);
    is_last       = (cnt == '0) || (i == cnt - 1'b1);
    sts.bad       = req.range_low > req.range_high;
    sts.scan_done = cmd.scan && done;
    sts.last_load = ld && is_last;
  end

  // request latch and rebuild
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      cnt <= '0;
      i   <= '0;
    end else if (cmd.load) begin
      op <= req.func; lo <= req.range_low; hi <= req.range_high;
      mlo <= req.range_low; mhi <= req.range_high;
      i <= '0; j <= '0; ins <= 1'b0; phase <= 1'b0; changed <= 1'b0; full <= 1'b0;
      status <= isar_pkg::ST_BADRANGE;
    end else if (cmd.scan) begin
      phase <= ph_next;
      if (set_chg) changed <= 1'b1;
      if (set_ins) ins <= 1'b1;
      if (merge) begin
        if (rlo < mlo) mlo <= rlo;
        if (rhi > mhi) mhi <= rhi;
      end
      if (wr) begin
        if (j == MAXC) begin
          full <= 1'b1;
        end else begin
          tab_low[~sel][j[isar_pkg::IDX_W-1:0]]  <= wlo;
          tab_high[~sel][j[isar_pkg::IDX_W-1:0]] <= whi;
          j <= j + 1'b1;
        end
      end
      if (adv) i <= i + 1'b1;
      if (done) begin
        i <= '0;
        if (fin_chg && !full) begin
          sel <= ~sel; cnt <= j; status <= isar_pkg::ST_CHANGED;
        end else if (fin_chg) begin
          status <= isar_pkg::ST_FULL;
        end else begin
          status <= isar_pkg::ST_UNCHANGED;
        end
      end
    end else if (ld) begin
      i <= i + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ld) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rsp.status      <= status;
      rsp.entry_valid <= (cnt != '0);
      rsp.entry_index <= 4'(i);
      rsp.entry_low   <= (cnt != '0) ? rlo : 32'sd0;
      rsp.entry_high  <= (cnt != '0) ? rhi : 32'sd0;
      rsp.entry_total <= 5'(cnt);
      rsp.last        <= is_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MAXC)
    else $error("interval count beyond table size");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.entry_valid |-> rsp.last) else $error("empty beat not last");
  a_full_no_commit: assert property (@(posedge clk) disable iff (rst)
    sts.scan_done && full |=> $stable(cnt)) else $error("full rebuild committed");

endmodule
